FILE: rtl/triangle_bitplane_rasterizer_unit_assert.svh
// Assertion macros for the bit-plane rasterizer.
`ifndef TRIANGLE_BITPLANE_RASTERIZER_UNIT_ASSERT_SVH
`define TRIANGLE_BITPLANE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TBR_ASSERT_IMP(label, clk, rst_n, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tbr assertion failed");

// Next-cycle implication, checked out of reset.
`define TBR_ASSERT_NXT(label, clk, rst_n, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tbr assertion failed");

`endif

FILE: rtl/tbr_pkg.sv
`timescale 1ns / 1ps
package tbr_pkg;
    localparam int WORD_BITS          = 64;
    localparam int MAX_PLANE_SIDE_DEF = 256;
    localparam int COORD_W            = 24;
    localparam int BOUND_W            = 16;
    localparam int ADDR_W             = 10;
    localparam int CMD_W              = 2;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 9;
    localparam int PWW_W              = 3;
    localparam int PH_W               = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 1'b1;

    localparam logic [PWW_W-1:0] PWW_RESET = 3'd4;
    localparam logic [PH_W-1:0]  PH_RESET  = 9'd256;

    localparam logic signed [BOUND_W-1:0] BOUND_LOW_RESET  = 16'sh7FFF;
    localparam logic signed [BOUND_W-1:0] BOUND_HIGH_RESET = 16'sh8000;
endpackage

FILE: rtl/tbr_if.sv
`timescale 1ns / 1ps
interface tbr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [tbr_pkg::CMD_W-1:0]              cmd;
    logic signed [tbr_pkg::COORD_W-1:0]     vert_a_x;
    logic signed [tbr_pkg::COORD_W-1:0]     vert_a_y;
    logic signed [tbr_pkg::COORD_W-1:0]     vert_b_x;
    logic signed [tbr_pkg::COORD_W-1:0]     vert_b_y;
    logic signed [tbr_pkg::COORD_W-1:0]     vert_c_x;
    logic signed [tbr_pkg::COORD_W-1:0]     vert_c_y;
    logic [tbr_pkg::ADDR_W-1:0]             word_addr;
    modport source (output valid, cmd, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                    vert_c_x, vert_c_y, word_addr, input ready);
    modport sink (input valid, cmd, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                  vert_c_x, vert_c_y, word_addr, output ready);
endinterface

interface tbr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [tbr_pkg::WORD_BITS-1:0]          read_word;
    logic signed [tbr_pkg::BOUND_W-1:0]     low_x;
    logic signed [tbr_pkg::BOUND_W-1:0]     high_x;
    logic signed [tbr_pkg::BOUND_W-1:0]     low_y;
    logic signed [tbr_pkg::BOUND_W-1:0]     high_y;
    modport source (output valid, read_word, low_x, high_x, low_y, high_y, input ready);
    modport sink (input valid, read_word, low_x, high_x, low_y, high_y, output ready);
endinterface

interface tbr_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [tbr_pkg::CFG_IDX_W-1:0]          index;
    logic [tbr_pkg::CFG_DATA_W-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/triangle_bitplane_rasterizer_unit.sv
`timescale 1ns / 1ps
// Channel  | dir | handshake      | payload
// i_in     | in  | valid / ready  | cmd, vert_{a,b,c}_{x,y}, word_addr
// o_out    | out | valid / ready  | read_word, low_x, high_x, low_y, high_y
// i_cfg    | in  | valid / ready  | index, data (ready always high)
// Reset runs a clearing pass over the plane memory, with input held off.
// Clear sweeps every plane word to zero; read fetches one word. Clear and read go
// through the plane memory; draw also uses the shared bit-serial divide / shift-add unit.
// Draw: three slope divides (a flat edge skips its divide), three start offsets, then for
// each walked row a span step and a pass over the w words, w = plane width in words.
// A finished result sits in the output register; a new item is taken meanwhile.
`include "triangle_bitplane_rasterizer_unit_assert.svh"
module triangle_bitplane_rasterizer_unit #(
    parameter int MAX_PLANE_SIDE = tbr_pkg::MAX_PLANE_SIDE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbr_in_if.sink    i_in,
    tbr_out_if.source o_out,
    tbr_cfg_if.sink   i_cfg
);
    localparam int WB          = tbr_pkg::WORD_BITS;
    localparam int PLANE_WORDS = MAX_PLANE_SIDE * MAX_PLANE_SIDE / WB;
    localparam int AW          = $clog2(PLANE_WORDS);
    localparam int RW          = $clog2(MAX_PLANE_SIDE);
    localparam int MAXW        = MAX_PLANE_SIDE / WB;
    localparam int WW          = $clog2(MAXW + 1);
    localparam int BI          = $clog2(WB);
    localparam int EW          = 52;
    localparam int SW          = 34;
    localparam int CW          = tbr_pkg::COORD_W;
    localparam int BW          = tbr_pkg::BOUND_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DIFF, S_PICK, S_ROWS, S_DIV_LD, S_DIV, S_MUL_LD, S_MUL,
        S_WALK, S_SPAN, S_WRD, S_WWR, S_FINAL, S_RD, S_RD2, S_DONE
    } t_state;

    t_state r_state;
    logic [AW:0] r_clr_cnt;
    logic        r_clr_resp;
    logic [tbr_pkg::PWW_W-1:0] r_pww;
    logic [tbr_pkg::PH_W-1:0]  r_ph;
    logic [tbr_pkg::ADDR_W-1:0] r_addr;
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [CW:0] r_ab, r_bc, r_ca;
    logic signed [CW-1:0] r_lsx, r_lsy, r_lex, r_ley, r_sx, r_sy;
    logic signed [BW-1:0] r_rs, r_re, r_rm;
    logic [1:0] r_k;
    logic [32:0] r_dv_q;
    logic [15:0] r_dv_r, r_dv_d;
    logic        r_dv_neg;
    logic [5:0]  r_dv_cnt;
    logic signed [SW-1:0] r_lstep, r_s1step, r_s2step;
    logic signed [EW-1:0] r_mc, r_acc;
    logic [15:0] r_mp;
    logic signed [EW-1:0] r_lx, r_s1x, r_s2x;
    logic signed [BW-1:0] r_y, r_ylast, r_lo, r_hi;
    logic [WW-1:0] r_w, r_cw;
    logic [WB-1:0] r_rdata, r_res_word;
    logic signed [BW-1:0] r_blx, r_bhx, r_bly, r_bhy;
    logic        r_out_valid;
    logic [WB-1:0] r_o_word;
    logic signed [BW-1:0] r_o_lx, r_o_hx, r_o_ly, r_o_hy;
    logic [WB-1:0] r_mem [PLANE_WORDS];

    // Truncate a 16.8 coordinate toward zero to a row.
    function automatic logic signed [BW-1:0] row_of(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        t = (CW+1)'(v) + (v[CW-1] ? (CW+1)'(255) : '0);
        return t[CW-1:8];
    endfunction

    // Column of a 16-fraction-bit x, truncated toward zero and saturated.
    function automatic logic signed [BW-1:0] col_of(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] t;
        logic signed [EW-17:0] c;
        t = x + (x[EW-1] ? EW'(65535) : '0);
        c = t[EW-1:16];
        if (c > (EW-16)'(32767)) return 16'sh7FFF;
        else if (c < (EW-16)'(-32768)) return 16'sh8000;
        else return c[BW-1:0];
    endfunction

    function automatic logic [CW:0] absdiff(input logic signed [CW-1:0] a,
                                           input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = (CW+1)'(a) - (CW+1)'(b);
        return d[CW] ? -d : d;
    endfunction

    // Edge operands picked by the edge counter
    logic signed [CW-1:0] e_x0, e_x1, m_x;
    logic signed [BW-1:0] e_r0, e_r1, m_r;
    logic signed [SW-1:0] m_step;
    always_comb begin
        case (r_k)
            2'd0: begin
                e_x0 = r_lsx; e_x1 = r_lex; e_r0 = r_rs; e_r1 = r_re;
                m_x = r_lsx; m_r = r_rs; m_step = r_lstep;
            end
            2'd1: begin
                e_x0 = r_lsx; e_x1 = r_sx; e_r0 = r_rs; e_r1 = r_rm;
                m_x = r_lsx; m_r = r_rs; m_step = r_s1step;
            end
            default: begin
                e_x0 = r_sx; e_x1 = r_lex; e_r0 = r_rm; e_r1 = r_re;
                m_x = r_sx; m_r = r_rm; m_step = r_s2step;
            end
        endcase
    end

    logic signed [CW:0] e_num;
    logic signed [BW:0] e_dr;
    logic [CW:0] e_num_mag;
    logic [BW:0] e_dr_mag;
    assign e_num     = (CW+1)'(e_x1) - (CW+1)'(e_x0);
    assign e_dr      = (BW+1)'(e_r1) - (BW+1)'(e_r0);
    assign e_num_mag = e_num[CW] ? -e_num : e_num;
    assign e_dr_mag  = e_dr[BW] ? -e_dr : e_dr;

    // Divider step: shift in one dividend bit, trial subtract
    logic [16:0] dv_sh;
    logic        dv_bit;
    logic [15:0] dv_rem;
    logic [32:0] dv_qn;
    logic signed [SW-1:0] dv_step;
    always_comb begin
        dv_sh  = {r_dv_r, r_dv_q[32]};
        dv_bit = dv_sh >= {1'b0, r_dv_d};
        dv_rem = dv_bit ? 16'(dv_sh - {1'b0, r_dv_d}) : dv_sh[15:0];
        dv_qn  = {r_dv_q[31:0], dv_bit};
        dv_step = r_dv_neg ? -$signed({1'b0, dv_qn}) : $signed({1'b0, dv_qn});
    end

    // Plane size clipped to the storage
    logic [31:0] w32, h32;
    logic signed [BW-1:0] hm1, ystart, ylast;
    assign w32    = (32'(r_pww) > 32'(MAXW)) ? 32'(MAXW) : 32'(r_pww);
    assign h32    = (32'(r_ph) > 32'(MAX_PLANE_SIDE)) ? 32'(MAX_PLANE_SIDE) : 32'(r_ph);
    assign hm1    = $signed(h32[BW-1:0]) - 16'sd1;
    assign ystart = (r_rs > 16'sd0) ? r_rs : 16'sd0;
    assign ylast  = (r_re < hm1) ? r_re : hm1;

    // Row span from the edge accumulators
    logic signed [BW-1:0] sp_x1, sp_x2, sp_s1, sp_s2;
    assign sp_x1 = col_of(r_lx);
    assign sp_s1 = col_of(r_s1x);
    assign sp_s2 = col_of(r_s2x);
    assign sp_x2 = (r_y < r_rm) ? sp_s1 : sp_s2;

    // Word cover test and mask for the current column word
    int          wbase, lb32, hb32;
    logic        w_cover;
    logic [BI-1:0] lb, hb;
    logic [WB-1:0] w_mask;
    logic [AW-1:0] w_idx;
    always_comb begin
        wbase   = int'(r_cw) * WB;
        lb32    = int'(r_lo) - wbase;
        hb32    = int'(r_hi) - wbase;
        w_cover = (int'(r_hi) >= wbase) && (int'(r_lo) < wbase + WB);
        lb      = (lb32 < 0) ? '0 : lb32[BI-1:0];
        hb      = (hb32 > WB - 1) ? BI'(WB - 1) : hb32[BI-1:0];
        w_mask  = ((hb == BI'(WB - 1)) ? '0 : (WB'(2) << hb)) - (WB'(1) << lb);
        w_idx   = AW'(r_y[RW-1:0]) * AW'(r_w) + AW'(r_cw);
    end

    // Read address: in range check against the store
    logic [31:0] rd_a32;
    logic        rd_ok;
    assign rd_a32 = 32'(r_addr);
    assign rd_ok  = rd_a32 < 32'(PLANE_WORDS);

    // Memory access controls
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [WB-1:0] mem_wdata;
    always_comb begin
        mem_we    = (r_state == S_CLEAR) || (r_state == S_WWR);
        mem_waddr = (r_state == S_CLEAR) ? r_clr_cnt[AW-1:0] : w_idx;
        mem_wdata = (r_state == S_CLEAR) ? '0 : (r_rdata | w_mask);
        mem_re    = ((r_state == S_RD) && rd_ok) || ((r_state == S_WRD) && (r_cw != r_w)
                    && w_cover);
        mem_raddr = (r_state == S_RD) ? rd_a32[AW-1:0] : w_idx;
    end

    // Plane store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pww <= tbr_pkg::PWW_RESET;
            r_ph  <= tbr_pkg::PH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tbr_pkg::CFG_PLANE_WIDTH:  r_pww <= i_cfg.data[tbr_pkg::PWW_W-1:0];
                tbr_pkg::CFG_PLANE_HEIGHT: r_ph  <= i_cfg.data[tbr_pkg::PH_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.read_word = r_o_word;
    assign o_out.low_x     = r_o_lx;
    assign o_out.high_x    = r_o_hx;
    assign o_out.low_y     = r_o_ly;
    assign o_out.high_y    = r_o_hy;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
            r_blx       <= tbr_pkg::BOUND_LOW_RESET;
            r_bhx       <= tbr_pkg::BOUND_HIGH_RESET;
            r_bly       <= tbr_pkg::BOUND_LOW_RESET;
            r_bhy       <= tbr_pkg::BOUND_HIGH_RESET;
        end else begin
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                // sweep the plane to zero
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == (AW+1)'(PLANE_WORDS - 1)) begin
                        r_state <= r_clr_resp ? S_DONE : S_IDLE;
                    end
                end
                // take a transfer and dispatch on the command
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ax <= i_in.vert_a_x; r_ay <= i_in.vert_a_y;
                        r_bx <= i_in.vert_b_x; r_by <= i_in.vert_b_y;
                        r_cx <= i_in.vert_c_x; r_cy <= i_in.vert_c_y;
                        r_addr     <= i_in.word_addr;
                        r_res_word <= '0;
                        case (i_in.cmd)
                            tbr_pkg::CMD_CLEAR: begin
                                r_blx      <= tbr_pkg::BOUND_LOW_RESET;
                                r_bhx      <= tbr_pkg::BOUND_HIGH_RESET;
                                r_bly      <= tbr_pkg::BOUND_LOW_RESET;
                                r_bhy      <= tbr_pkg::BOUND_HIGH_RESET;
                                r_clr_cnt  <= '0;
                                r_clr_resp <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            tbr_pkg::CMD_DRAW: r_state <= S_DIFF;
                            tbr_pkg::CMD_READ: r_state <= S_RD;
                            default:           r_state <= S_DONE;
                        endcase
                    end
                end
                S_DIFF: begin
                    r_ab <= absdiff(r_by, r_ay);
                    r_bc <= absdiff(r_cy, r_by);
                    r_ca <= absdiff(r_ay, r_cy);
                    r_state <= S_PICK;
                end
                // choose the long side and its upper end
                S_PICK: begin
                    if (r_ab >= r_bc && r_ab >= r_ca) begin
                        r_sx <= r_cx; r_sy <= r_cy;
                        if (r_ay < r_by) begin
                            r_lsx <= r_ax; r_lsy <= r_ay; r_lex <= r_bx; r_ley <= r_by;
                        end else begin
                            r_lsx <= r_bx; r_lsy <= r_by; r_lex <= r_ax; r_ley <= r_ay;
                        end
                    end else if (r_bc >= r_ab && r_bc >= r_ca) begin
                        r_sx <= r_ax; r_sy <= r_ay;
                        if (r_by < r_cy) begin
                            r_lsx <= r_bx; r_lsy <= r_by; r_lex <= r_cx; r_ley <= r_cy;
                        end else begin
                            r_lsx <= r_cx; r_lsy <= r_cy; r_lex <= r_bx; r_ley <= r_by;
                        end
                    end else begin
                        r_sx <= r_bx; r_sy <= r_by;
                        if (r_cy < r_ay) begin
                            r_lsx <= r_cx; r_lsy <= r_cy; r_lex <= r_ax; r_ley <= r_ay;
                        end else begin
                            r_lsx <= r_ax; r_lsy <= r_ay; r_lex <= r_cx; r_ley <= r_cy;
                        end
                    end
                    r_state <= S_ROWS;
                end
                S_ROWS: begin
                    r_rs    <= row_of(r_lsy);
                    r_re    <= row_of(r_ley);
                    r_rm    <= row_of(r_sy);
                    r_k     <= 2'd0;
                    r_state <= S_DIV_LD;
                end
                // load the divider for one edge slope; a flat edge gets a zero slope
                S_DIV_LD: begin
                    if (e_dr == '0) begin
                        case (r_k)
                            2'd0:    r_lstep  <= '0;
                            2'd1:    r_s1step <= '0;
                            default: r_s2step <= '0;
                        endcase
                        if (r_k == 2'd2) begin
                            r_k <= 2'd0;
                            r_state <= S_MUL_LD;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else begin
                        r_dv_q   <= {e_num_mag, 8'b0};
                        r_dv_r   <= '0;
                        r_dv_d   <= e_dr_mag[15:0];
                        r_dv_neg <= e_num[CW] ^ e_dr[BW];
                        r_dv_cnt <= 6'd33;
                        r_state  <= S_DIV;
                    end
                end
                // one quotient bit per cycle
                S_DIV: begin
                    r_dv_q   <= dv_qn;
                    r_dv_r   <= dv_rem;
                    r_dv_cnt <= r_dv_cnt - 6'd1;
                    if (r_dv_cnt == 6'd1) begin
                        case (r_k)
                            2'd0:    r_lstep  <= dv_step;
                            2'd1:    r_s1step <= dv_step;
                            default: r_s2step <= dv_step;
                        endcase
                        if (r_k == 2'd2) begin
                            r_k <= 2'd0;
                            r_state <= S_MUL_LD;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_state <= S_DIV_LD;
                        end
                    end
                end
                // start offset for an edge that begins above row zero
                S_MUL_LD: begin
                    r_acc   <= EW'(m_x) <<< 8;
                    r_mc    <= EW'(m_step);
                    r_mp    <= (m_r < 16'sd0) ? 16'(-(BW+1)'(m_r)) : '0;
                    r_state <= S_MUL;
                end
                // shift-add until the multiplier is used up
                S_MUL: begin
                    if (r_mp == '0) begin
                        case (r_k)
                            2'd0:    r_lx  <= r_acc;
                            2'd1:    r_s1x <= r_acc;
                            default: r_s2x <= r_acc;
                        endcase
                        if (r_k == 2'd2) begin
                            r_state <= S_WALK;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_state <= S_MUL_LD;
                        end
                    end else begin
                        if (r_mp[0]) begin
                            r_acc <= r_acc + r_mc;
                        end
                        r_mc <= r_mc <<< 1;
                        r_mp <= r_mp >> 1;
                    end
                end
                S_WALK: begin
                    r_y     <= ystart;
                    r_ylast <= ylast;
                    r_w     <= w32[WW-1:0];
                    r_state <= (ystart > ylast) ? S_FINAL : S_SPAN;
                end
                // span of one row, advance edges, widen x bounds
                S_SPAN: begin
                    r_lo <= (sp_x1 < sp_x2) ? sp_x1 : sp_x2;
                    r_hi <= (sp_x1 < sp_x2) ? sp_x2 : sp_x1;
                    if (((sp_x1 < sp_x2) ? sp_x1 : sp_x2) < r_blx) begin
                        r_blx <= (sp_x1 < sp_x2) ? sp_x1 : sp_x2;
                    end
                    if (((sp_x1 < sp_x2) ? sp_x2 : sp_x1) > r_bhx) begin
                        r_bhx <= (sp_x1 < sp_x2) ? sp_x2 : sp_x1;
                    end
                    r_lx <= r_lx + EW'(r_lstep);
                    if (r_y < r_rm) begin
                        r_s1x <= r_s1x + EW'(r_s1step);
                    end else begin
                        r_s2x <= r_s2x + EW'(r_s2step);
                    end
                    r_cw    <= '0;
                    r_state <= S_WRD;
                end
                // read a covered word, step past an uncovered one, or end the row
                S_WRD: begin
                    if (r_cw == r_w) begin
                        r_y     <= r_y + 16'sd1;
                        r_state <= (r_y == r_ylast) ? S_FINAL : S_SPAN;
                    end else if (w_cover) begin
                        r_state <= S_WWR;
                    end else begin
                        r_cw <= r_cw + 1'b1;
                    end
                end
                S_WWR: begin
                    r_cw    <= r_cw + 1'b1;
                    r_state <= S_WRD;
                end
                // widen y bounds by the long edge rows
                S_FINAL: begin
                    if (r_rs < r_bly) begin
                        r_bly <= r_rs;
                    end
                    if (r_re > r_bhy) begin
                        r_bhy <= r_re;
                    end
                    r_state <= S_DONE;
                end
                S_RD: r_state <= rd_ok ? S_RD2 : S_DONE;
                S_RD2: begin
                    r_res_word <= r_rdata;
                    r_state    <= S_DONE;
                end
                // hand the result to the output register once it is free
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_word    <= r_res_word;
                        r_o_lx      <= r_blx;
                        r_o_hx      <= r_bhx;
                        r_o_ly      <= r_bly;
                        r_o_hy      <= r_bhy;
                        r_clr_resp  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Bound order and output load conditions
    logic xb_ok, yb_ok, done_fire;
    assign xb_ok     = (r_blx <= r_bhx) || ((r_blx == tbr_pkg::BOUND_LOW_RESET)
                       && (r_bhx == tbr_pkg::BOUND_HIGH_RESET));
    assign yb_ok     = (r_bly <= r_bhy) || ((r_bly == tbr_pkg::BOUND_LOW_RESET)
                       && (r_bhy == tbr_pkg::BOUND_HIGH_RESET));
    assign done_fire = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    `TBR_ASSERT_IMP(a_clear_holds_input, i_clk, i_rst_n, r_state == S_CLEAR, !i_in.ready)
    `TBR_ASSERT_IMP(a_xbounds_order, i_clk, i_rst_n, 1'b1, xb_ok)
    `TBR_ASSERT_IMP(a_ybounds_order, i_clk, i_rst_n, 1'b1, yb_ok)
    `TBR_ASSERT_IMP(a_write_span_ordered, i_clk, i_rst_n, r_state == S_WWR, r_lo <= r_hi)
    `TBR_ASSERT_NXT(a_done_loads_output, i_clk, i_rst_n, done_fire, r_out_valid && r_state == S_IDLE)
endmodule

FILE: bench/tb_triangle_bitplane_rasterizer_unit.sv
`timescale 1ns / 1ps
module tb_triangle_bitplane_rasterizer_unit;
    localparam int PLANE_WORDS = 1024;
    localparam int IDLE_LIMIT  = 200000;

    typedef struct packed {
        logic [63:0]        word;
        logic signed [15:0] lx;
        logic signed [15:0] hx;
        logic signed [15:0] ly;
        logic signed [15:0] hy;
    } raster_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tbr_in_if  in_ch();
    tbr_out_if out_ch();
    tbr_cfg_if cfg_ch();

    triangle_bitplane_rasterizer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state
    logic [63:0]    shadow_plane [PLANE_WORDS];
    int             pred_low_x, pred_high_x, pred_low_y, pred_high_y;
    int unsigned    pred_width, pred_height;
    raster_result_t pending_results[$];

    int  mismatches = 0;
    int  checked = 0;
    int  idle_cycles = 0;
    int  draws_sent = 0;
    int  reads_sent = 0;
    bit  timed_out = 0;
    bit  long_hold = 0;
    bit  hold_req = 0;
    int  gap_chance = 30;

    function automatic longint unsigned abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int column_of(longint x16);
        longint c;
        c = x16 / 65536;
        if (c < -32768) c = -32768;
        if (c > 32767) c = 32767;
        return int'(c);
    endfunction

    function automatic longint slope(longint x0, longint x1, int r0, int r1);
        longint dr;
        dr = longint'(r1) - longint'(r0);
        if (dr == 0) return 0;
        return ((x1 - x0) * 256) / dr;
    endfunction

    task automatic walk_rows(longint lsx, longint lsy, longint lex, longint ley,
                             longint sx, longint sy);
        int rs, re, rm, y, ylast, h, x1, x2, lo, hi, lb, hb, base;
        int unsigned w, idx;
        longint lstep, s1step, s2step, lx, s1x, s2x;
        logic [63:0] bits;
        rs = int'(lsy / 256);
        re = int'(ley / 256);
        rm = int'(sy / 256);
        lstep  = slope(lsx, lex, rs, re);
        s1step = slope(lsx, sx, rs, rm);
        s2step = slope(sx, lex, rm, re);
        lx  = lsx * 256 + (rs < 0 ? longint'(-rs) * lstep : 0);
        s1x = lsx * 256 + (rs < 0 ? longint'(-rs) * s1step : 0);
        s2x = sx * 256 + (rm < 0 ? longint'(-rm) * s2step : 0);
        w = pred_width > 4 ? 4 : pred_width;
        h = int'(pred_height > 256 ? 256 : pred_height);
        y = rs > 0 ? rs : 0;
        ylast = re < h - 1 ? re : h - 1;
        for (; y <= ylast; y++) begin
            x1 = column_of(lx);
            lx += lstep;
            if (y < rm) begin
                x2 = column_of(s1x);
                s1x += s1step;
            end else begin
                x2 = column_of(s2x);
                s2x += s2step;
            end
            lo = x1 < x2 ? x1 : x2;
            hi = x1 < x2 ? x2 : x1;
            for (int cw = 0; cw < int'(w); cw++) begin
                base = cw * 64;
                if (hi >= base && lo < base + 64) begin
                    lb = lo - base;
                    hb = hi - base;
                    if (lb < 0) lb = 0;
                    if (hb > 63) hb = 63;
                    bits = (hb == 63 ? 64'd0 : (64'd2 << hb)) - (64'd1 << lb);
                    idx = y * w + cw;
                    if (idx < PLANE_WORDS) shadow_plane[idx] |= bits;
                end
            end
            if (lo < pred_low_x) pred_low_x = lo;
            if (hi > pred_high_x) pred_high_x = hi;
        end
        if (rs < pred_low_y) pred_low_y = rs;
        if (re > pred_high_y) pred_high_y = re;
    endtask

    task automatic clear_shadow();
        foreach (shadow_plane[i]) shadow_plane[i] = '0;
        pred_low_x = 32767;
        pred_high_x = -32768;
        pred_low_y = 32767;
        pred_high_y = -32768;
    endtask

    // Compute the expected result of one item and queue it
    task automatic predict_item(logic [1:0] cmd, logic signed [23:0] v[6],
                                logic [9:0] addr);
        longint ax, ay, bx, by, cx, cy;
        longint unsigned ab, bc, ca;
        raster_result_t r;
        r.word = '0;
        if (cmd == tbr_pkg::CMD_CLEAR) begin
            clear_shadow();
        end else if (cmd == tbr_pkg::CMD_DRAW) begin
            ax = v[0]; ay = v[1]; bx = v[2]; by = v[3]; cx = v[4]; cy = v[5];
            ab = abs_l(by - ay);
            bc = abs_l(cy - by);
            ca = abs_l(ay - cy);
            if (ab >= bc && ab >= ca) begin
                if (ay < by) walk_rows(ax, ay, bx, by, cx, cy);
                else walk_rows(bx, by, ax, ay, cx, cy);
            end else if (bc >= ab && bc >= ca) begin
                if (by < cy) walk_rows(bx, by, cx, cy, ax, ay);
                else walk_rows(cx, cy, bx, by, ax, ay);
            end else begin
                if (cy < ay) walk_rows(cx, cy, ax, ay, bx, by);
                else walk_rows(ax, ay, cx, cy, bx, by);
            end
        end else if (cmd == tbr_pkg::CMD_READ) begin
            r.word = shadow_plane[addr];
        end
        r.lx = 16'(pred_low_x);
        r.hx = 16'(pred_high_x);
        r.ly = 16'(pred_low_y);
        r.hy = 16'(pred_high_y);
        pending_results.push_back(r);
    endtask

    // Offer one item, honoring the burst/gap pattern, and wait for its transfer
    task automatic send_item(logic [1:0] cmd, logic signed [23:0] v[6], logic [9:0] addr);
        if ($urandom_range(99) < gap_chance) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= cmd;
        in_ch.vert_a_x <= v[0];
        in_ch.vert_a_y <= v[1];
        in_ch.vert_b_x <= v[2];
        in_ch.vert_b_y <= v[3];
        in_ch.vert_c_x <= v[4];
        in_ch.vert_c_y <= v[5];
        in_ch.word_addr <= addr;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(cmd, v, addr);
        if (cmd == tbr_pkg::CMD_DRAW) draws_sent++;
        if (cmd == tbr_pkg::CMD_READ) reads_sent++;
    endtask

    task automatic send_simple(logic [1:0] cmd, logic [9:0] addr);
        logic signed [23:0] v[6];
        foreach (v[i]) v[i] = 24'($urandom);
        send_item(cmd, v, addr);
    endtask

    task automatic send_tri(int ax, int ay, int bx, int by, int cx, int cy);
        logic signed [23:0] v[6];
        v[0] = 24'(ax); v[1] = 24'(ay); v[2] = 24'(bx);
        v[3] = 24'(by); v[4] = 24'(cx); v[5] = 24'(cy);
        send_item(tbr_pkg::CMD_DRAW, v, 10'($urandom));
    endtask

    // Drop valid and wait until every expected result has come back, plus slack
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tbr_pkg::CFG_IDX_W-1:0] idx, logic [8:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == tbr_pkg::CFG_PLANE_WIDTH) pred_width = val[2:0];
        else pred_height = val;
    endtask

    task automatic set_plane(logic [8:0] w, logic [8:0] h);
        drain();
        write_reg(tbr_pkg::CFG_PLANE_WIDTH, w);
        write_reg(tbr_pkg::CFG_PLANE_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
    endtask

    // Read back every word a small plane can touch
    task automatic read_plane(int words);
        for (int a = 0; a < words; a++) send_simple(tbr_pkg::CMD_READ, 10'(a));
    endtask

    function automatic int rand_coord(int span);
        return $urandom_range(0, span * 256) - 4 * 256;
    endfunction

    task automatic test_directed();
        logic signed [23:0] v[6];
        send_simple(tbr_pkg::CMD_READ, 10'd0);
        send_tri(0, 0, 255 * 256, 255 * 256, 0, 255 * 256);
        send_tri(10 * 256, 5 * 256, 200 * 256 + 77, 5 * 256 + 3, 100 * 256, 40 * 256);
        send_tri(-50 * 256, -30 * 256, 300 * 256, 20 * 256, 40 * 256, 300 * 256);
        send_tri(5 * 256, 7 * 256, 9 * 256, 7 * 256, 60 * 256, 7 * 256);
        send_tri(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607);
        send_tri(8388607, -8388608, -8388608, 8388607, 8388607, 0);
        send_tri(-300, -300, -100, 500, 300, -700);
        foreach (v[i]) v[i] = 24'h800000;
        send_item(tbr_pkg::CMD_DRAW, v, 10'h3FF);
        send_simple(tbr_pkg::CMD_READ, 10'd1023);
        send_simple(tbr_pkg::CMD_READ, 10'd5);
        send_simple(tbr_pkg::CMD_READ, 10'd300);
        send_simple(tbr_pkg::CMD_NONE, 10'd5);
        send_simple(tbr_pkg::CMD_CLEAR, 10'd0);
        send_simple(tbr_pkg::CMD_READ, 10'd5);
    endtask

    task automatic test_config_extremes();
        set_plane(9'd1, 9'd1);
        send_tri(0, 0, 100 * 256, 10 * 256, 0, 10 * 256);
        read_plane(4);
        set_plane(9'd7, 9'd511);
        send_tri(-1000, 0, 400 * 256, 300 * 256, 0, 300 * 256);
        send_simple(tbr_pkg::CMD_READ, 10'd1023);
        set_plane(9'd0, 9'd0);
        send_tri(0, 0, 50 * 256, 50 * 256, 0, 50 * 256);
        send_simple(tbr_pkg::CMD_READ, 10'd0);
        set_plane(9'd2, 9'd256);
        send_simple(tbr_pkg::CMD_CLEAR, 10'd0);
    endtask

    task automatic test_random(int n, int w, int h);
        int op, sp;
        set_plane(9'(w), 9'(h));
        for (int i = 0; i < n && !timed_out; i++) begin
            op = $urandom_range(99);
            sp = $urandom_range(99) < 85 ? 24 : 320;
            if (op < 3) send_simple(tbr_pkg::CMD_CLEAR, 10'd0);
            else if (op < 5) send_simple(tbr_pkg::CMD_NONE, 10'($urandom));
            else if (op < 45) send_tri(rand_coord(sp), rand_coord(sp), rand_coord(sp),
                                       rand_coord(sp), rand_coord(sp), rand_coord(sp));
            else if (op < 48) send_simple(tbr_pkg::CMD_DRAW, 10'd0);
            else if (op < 90) send_simple(tbr_pkg::CMD_READ,
                                          10'($urandom_range(0, 4 * 30)));
            else send_simple(tbr_pkg::CMD_READ, 10'($urandom));
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_req = 1'b1;
        gap_chance = 0;
        for (int i = 0; i < 12; i++) send_simple(tbr_pkg::CMD_READ, 10'(i));
        hold_req = 1'b0;
        gap_chance = 30;
    endtask

    // Receiver stall pattern, with a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (long_hold) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) < 65);
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                long_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                long_hold = 1'b0;
                wait (!hold_req);
            end
        end
    end

    // Compare each transfer on the output with the oldest expectation
    always @(posedge i_clk) begin
        raster_result_t exp_r, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.read_word, out_ch.low_x, out_ch.high_x, out_ch.low_y,
                   out_ch.high_y};
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp word %h bounds %0d %0d %0d %0d, ",
                                  "got %h %0d %0d %0d %0d"},
                                 exp_r.word, exp_r.lx, exp_r.hx, exp_r.ly, exp_r.hy,
                                 got.word, got.lx, got.hx, got.ly, got.hy);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = tbr_pkg::CMD_CLEAR;
        in_ch.vert_a_x = '0; in_ch.vert_a_y = '0;
        in_ch.vert_b_x = '0; in_ch.vert_b_y = '0;
        in_ch.vert_c_x = '0; in_ch.vert_c_y = '0;
        in_ch.word_addr = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = tbr_pkg::CFG_PLANE_WIDTH;
        cfg_ch.data = '0;
        pred_width = tbr_pkg::PWW_RESET;
        pred_height = tbr_pkg::PH_RESET;
        clear_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random(250, 4, 40);
        test_random(250, 1, 64);
        test_random(250, 3, 256);
        drain();
        $display("Covered %0d draws, %0d reads, %0d results checked across plane settings",
                 draws_sent, reads_sent, checked);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/tbr_pkg.sv
rtl/tbr_if.sv
rtl/triangle_bitplane_rasterizer_unit.sv
bench/tb_triangle_bitplane_rasterizer_unit.sv
